// ----- rtl/jlsp_pkg.sv -----
`default_nettype none
package jlsp_pkg;

  // Default speed and acceleration word width
  localparam int VALUE_WIDTH_DEF = 32;
  // Width of intermediate sums, enough for every supported value width
  localparam int WIDE_W = 66;

  // Configuration register indexes
  localparam logic [1:0] CFG_JERK_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_MAX_ACCEL    = 2'd1;
  localparam logic [1:0] CFG_TICK_PERIOD  = 2'd2;
  localparam logic [1:0] CFG_PUBLISH      = 2'd3;

  // Configuration reset values
  localparam logic [30:0] JERK_LIMIT_RST  = 31'd32768;
  localparam logic [30:0] MAX_ACCEL_RST   = 31'd32768;
  localparam logic [31:0] TICK_PERIOD_RST = 32'd4294967;
  localparam logic [3:0]  PUBLISH_RST     = 4'd10;

  // Item kinds
  localparam logic KIND_TARGET = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] set_speed;
  } in_t;

  typedef struct packed {
    logic signed [31:0] speed_out;
    logic signed [31:0] accel_out;
    logic signed [31:0] jerk_out;
  } out_t;

endpackage
`default_nettype wire

// ----- rtl/jerk_limited_speed_profile.sv -----
`default_nettype none
// Jerk-limited S-curve speed generator.
// Input channel (in_valid/in_stall, in_data): a transaction is either a new
// target speed or one timer tick. The block takes one transaction at a time
// and holds in_stall high while it works on it.
// A target transaction runs the shared 64-bit restoring divider twice
// (max_accel^2 / jerk and accel^2 / 2*jerk); these runs set its length. A
// change that arrives in constant acceleration skips the second run; a target
// equal to the current one ends right after the check.
// A tick transaction makes four passes through the shared 32x32 multiplier
// plus phase and publish steps. When the tick counter matches publish_every
// the tick leaves one result transaction in the output register
// (out_valid/out_stall, out_data); out_valid is set by the publish step.
// A waiting result does not block new input; only a tick that must publish
// while the previous result is still stalled waits for the receiver.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready and
// is meant to be written while the block is idle.
// Reset (rst, synchronous) clears speed, acceleration, target and switch
// speeds, enters the hold phase, drops out_valid and loads default settings.
module jerk_limited_speed_profile #(
  parameter int VALUE_WIDTH = jlsp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire jlsp_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output jlsp_pkg::out_t     out_data,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data
);

  localparam int W  = VALUE_WIDTH;
  localparam int XW = jlsp_pkg::WIDE_W;
  localparam logic signed [XW-1:0] VMAX = (XW'(1) << (W - 1)) - XW'(1);
  localparam logic signed [XW-1:0] VMIN = -VMAX - XW'(1);
  localparam logic signed [XW-1:0] O32MAX = XW'(64'h7FFF_FFFF);
  localparam logic signed [XW-1:0] O32MIN = -O32MAX - XW'(1);

  typedef enum logic [1:0] {PH_UP, PH_CONST, PH_DOWN, PH_HOLD} phase_t;
  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_TSQ, S_TDS1, S_TDW1, S_TSQB, S_TDS2, S_TDW2, S_TV0, S_TSW,
    S_KPH, S_KM1, S_KM2, S_KM3, S_KM4, S_KM5, S_KOUT
  } state_t;

  function automatic logic signed [W-1:0] satv(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] r;
    r = x;
    if (x > VMAX) r = VMAX;
    if (x < VMIN) r = VMIN;
    return r[W-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] r;
    r = x;
    if (x > O32MAX) r = O32MAX;
    if (x < O32MIN) r = O32MIN;
    return r[31:0];
  endfunction

  function automatic logic signed [W-1:0] qsat(input logic [63:0] q);
    logic signed [W-1:0] r;
    if (q > 64'(VMAX)) r = VMAX[W-1:0];
    else r = q[W-1:0];
    return r;
  endfunction

  // Configuration
  logic [30:0] jerk_limit;
  logic [30:0] max_accel;
  logic [31:0] tick_period;
  logic [3:0]  publish_every;

  // Profile state
  state_t              state;
  phase_t              phase;
  jlsp_pkg::in_t       item;
  logic signed [W-1:0] cur_speed, accel_now, target_reg, sw_one, sw_two;
  logic signed [W-1:0] half, thr, sgn_half, v0;
  logic                dir_neg, short_prof;
  logic [3:0]          tick_count;
  logic signed [31:0]  jerk;
  logic signed [W-1:0] half_term;
  logic [31:0]         accel_lo;
  logic                pub_load;

  // Shared units
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic        div_start, div_done;
  logic [63:0] div_dividend, quot;
  logic [31:0] div_divisor;

  logic [30:0]          je;
  logic signed [W-1:0]  nt;
  logic signed [XW-1:0] accel_w, accel_abs, diff, sum2;
  logic [63:0]          accel_mag;
  logic [63:0]          accel_sq_in;
  logic signed [XW-1:0] jt_s, ad_s, hsum;
  logic [63:0]          r_acc;

  jlsp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));
  jlsp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(quot)
  );

  assign je        = (jerk_limit == '0) ? 31'd1 : jerk_limit;
  assign nt        = satv(XW'(item.set_speed));
  assign accel_w   = XW'(accel_now);
  assign accel_abs = accel_w[XW-1] ? -accel_w : accel_w;
  assign accel_mag = accel_abs[63:0];
  assign accel_sq_in = (accel_mag > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : accel_mag;
  assign diff      = (XW'(target_reg) - XW'(v0)) < 0 ? XW'(v0) - XW'(target_reg)
                                                     : XW'(target_reg) - XW'(v0);
  assign sum2      = XW'(target_reg) + XW'(v0);
  assign jt_s      = jerk[31] ? -XW'(prod[63:32]) : XW'(prod[63:32]);
  assign r_acc     = prod + 64'(accel_lo);
  assign ad_s      = accel_now[W-1] ? -XW'(r_acc) : XW'(r_acc);
  assign hsum      = XW'(cur_speed) + ad_s + XW'(half_term);

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // Publishing tick that can load the output register this cycle
  assign pub_load  = (state == S_KOUT) && (tick_count == publish_every) &&
                     (!out_valid || !out_stall);

  // Operand selection for the shared units
  always_comb begin
    mul_a        = '0;
    mul_b        = tick_period;
    div_start    = 1'b0;
    div_dividend = prod;
    div_divisor  = {1'b0, je};
    unique case (state)
      S_TSQ: begin
        mul_a = {1'b0, max_accel};
        mul_b = {1'b0, max_accel};
      end
      S_TSQB: begin
        mul_a = accel_sq_in[31:0];
        mul_b = accel_sq_in[31:0];
      end
      S_TDS1: div_start = 1'b1;
      S_TDS2: begin
        div_start   = 1'b1;
        div_divisor = {je, 1'b0};
      end
      S_KM1:  mul_a = jerk[31] ? 32'(-jerk) : 32'(jerk);
      S_KM2:  mul_a = prod[63:32];
      S_KM3:  mul_a = accel_mag[31:0];
      S_KM4:  mul_a = accel_mag[63:32];
      default: ;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      jerk_limit    <= jlsp_pkg::JERK_LIMIT_RST;
      max_accel     <= jlsp_pkg::MAX_ACCEL_RST;
      tick_period   <= jlsp_pkg::TICK_PERIOD_RST;
      publish_every <= jlsp_pkg::PUBLISH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jlsp_pkg::CFG_JERK_LIMIT:  jerk_limit    <= cfg_data[30:0];
        jlsp_pkg::CFG_MAX_ACCEL:   max_accel     <= cfg_data[30:0];
        jlsp_pkg::CFG_TICK_PERIOD: tick_period   <= cfg_data;
        jlsp_pkg::CFG_PUBLISH:     publish_every <= cfg_data[3:0];
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    logic signed [31:0] jv;
    logic signed [XW-1:0] av;
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_HOLD;
      cur_speed  <= '0;
      accel_now  <= '0;
      target_reg <= '0;
      sw_one     <= '0;
      sw_two     <= '0;
      dir_neg    <= 1'b0;
      short_prof <= 1'b0;
      tick_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (pub_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          item  <= in_data;
          state <= S_CHK;
        end
        S_CHK: begin
          if (item.kind == jlsp_pkg::KIND_TICK) begin
            state <= S_KPH;
          end else if (nt == target_reg) begin
            state <= S_IDLE;
          end else begin
            target_reg <= nt;
            if (phase != PH_CONST) phase <= PH_UP;
            if (nt > cur_speed) dir_neg <= 1'b0;
            else if (nt < cur_speed) dir_neg <= 1'b1;
            state <= S_TSQ;
          end
        end
        S_TSQ:  state <= S_TDS1;
        S_TDS1: state <= S_TDW1;
        S_TDW1: if (div_done) begin
          thr  <= qsat(quot);
          half <= qsat({1'b0, quot[63:1]});
          if (phase == PH_CONST) begin
            sgn_half <= qsat({1'b0, quot[63:1]});
            state    <= S_TV0;
          end else begin
            state <= S_TSQB;
          end
        end
        S_TSQB: state <= S_TDS2;
        S_TDS2: state <= S_TDW2;
        S_TDW2: if (div_done) begin
          sgn_half <= qsat(quot);
          state    <= S_TV0;
        end
        S_TV0: begin
          v0 <= satv(dir_neg ? XW'(cur_speed) + XW'(sgn_half)
                             : XW'(cur_speed) - XW'(sgn_half));
          state <= S_TSW;
        end
        S_TSW: begin
          if (diff >= XW'(thr)) begin
            short_prof <= 1'b0;
            sw_one <= satv(dir_neg ? XW'(v0) - XW'(half) : XW'(v0) + XW'(half));
            sw_two <= satv(dir_neg ? XW'(target_reg) + XW'(half)
                                   : XW'(target_reg) - XW'(half));
          end else begin
            short_prof <= 1'b1;
            // midpoint, truncated toward zero
            sw_one <= satv((sum2 + $signed(XW'(sum2[XW-1]))) >>> 1);
          end
          state <= S_IDLE;
        end
        // Phase rules for one tick
        S_KPH: begin
          jv = dir_neg ? -32'(je) : 32'(je);
          av = dir_neg ? -XW'(max_accel) : XW'(max_accel);
          unique case (phase)
            PH_UP: begin
              if (dir_neg ? cur_speed < sw_one : cur_speed > sw_one) begin
                if (short_prof) begin
                  jv = -jv;
                  phase <= PH_DOWN;
                end else begin
                  jv = '0;
                  phase <= PH_CONST;
                end
              end
            end
            PH_CONST: begin
              if (dir_neg ? cur_speed < sw_two : cur_speed > sw_two) begin
                jv = -jv;
                accel_now <= satv(av);
                phase <= PH_DOWN;
              end else begin
                jv = '0;
              end
            end
            PH_DOWN: begin
              jv = -jv;
              if (dir_neg ? (!accel_now[W-1] || cur_speed < target_reg)
                          : (accel_now[W-1] || accel_now == '0 ||
                             cur_speed > target_reg)) begin
                phase     <= PH_HOLD;
                accel_now <= '0;
                jv        = '0;
                cur_speed <= target_reg;
              end
            end
            PH_HOLD: begin
              cur_speed <= target_reg;
              jv        = '0;
              accel_now <= '0;
            end
          endcase
          jerk  <= jv;
          state <= S_KM1;
        end
        S_KM1: state <= S_KM2;
        S_KM2: begin
          accel_now <= satv(accel_w + jt_s);
          state     <= S_KM3;
        end
        S_KM3: begin
          half_term <= W'(jerk[31] ? -XW'(prod[63:33]) : XW'(prod[63:33]));
          state     <= S_KM4;
        end
        S_KM4: begin
          accel_lo <= prod[63:32];
          state    <= S_KM5;
        end
        S_KM5: begin
          cur_speed <= satv(hsum);
          state     <= S_KOUT;
        end
        // Publish counter and result register
        S_KOUT: begin
          if (tick_count == publish_every) begin
            if (pub_load) begin
              out_data.speed_out <= sat32(XW'(cur_speed));
              out_data.accel_out <= sat32(accel_w);
              out_data.jerk_out  <= jerk;
              tick_count <= 4'd1;
              state      <= S_IDLE;
            end
          end else begin
            tick_count <= tick_count + 4'd1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/jlsp_mul.sv -----
`default_nettype none
// Shared 32x32 unsigned multiplier, product registered
module jlsp_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule
`default_nettype wire

// ----- rtl/jlsp_div.sv -----
`default_nettype none
// Restoring divider, one quotient bit per cycle, 64 quotient bits
module jlsp_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic      [63:0] quotient
);

  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic        run;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem, quotient[63]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= '0;
        quotient <= dividend;
        dvs      <= divisor;
        cnt      <= '0;
        run      <= 1'b1;
      end else if (run) begin
        rem      <= fits ? 32'(trial - {1'b0, dvs}) : trial[31:0];
        quotient <= {quotient[62:0], fits};
        cnt      <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/jlsp_checker.sv -----
`default_nettype none
// Port-level checks for the speed profile generator
module jlsp_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire jlsp_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire jlsp_pkg::out_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // One transaction at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  // A target transaction never produces a result
  a_target_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.kind == jlsp_pkg::KIND_TARGET
    |=> !$rose(out_valid))
    else $error("result after a target transaction");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind jerk_limited_speed_profile jlsp_checker u_jlsp_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);
`default_nettype wire
